FILE: sv/gb5_pkg.sv
// ----------------------------------------------------------------------------
// gb5_pkg: shared definitions of the 5x5 Gaussian blur unit
// Frame limits, register indexes, kernel weights and the reciprocal that
// replaces the division by the kernel sum.
// ----------------------------------------------------------------------------
`default_nettype none

package gb5_pkg;

  // Largest supported row length and the widths that follow from it.
  localparam int MaxWidth  = 2048;
  localparam int ColBits   = $clog2(MaxWidth);
  localparam int WBits     = ColBits + 1;
  localparam int CfgWBits  = 12;
  localparam int CntWBits  = (WBits > CfgWBits) ? WBits : CfgWBits;
  localparam int HBits     = 16;
  // The input row runs two rows past the frame while the pipeline drains.
  localparam int RowBits   = HBits + 2;

  // Configuration port.
  localparam int CfgIdxBits  = 4;
  localparam int CfgDataBits = 16;
  localparam logic [CfgIdxBits-1:0] RegFrameWidth  = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] RegFrameHeight = CfgIdxBits'(1);
  localparam logic [CfgWBits-1:0]   FrameWidthRst  = CfgWBits'(640);
  localparam logic [HBits-1:0]      FrameHeightRst = HBits'(480);

  // Input command codes.
  localparam logic CmdPixel = 1'b0;
  localparam logic CmdDrain = 1'b1;

  // Kernel weights, row by row; they sum to 273.
  localparam logic [5:0] Kernel [25] = '{
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd7, 6'd26, 6'd41, 6'd26, 6'd7,
    6'd4, 6'd16, 6'd26, 6'd16, 6'd4,
    6'd1, 6'd4,  6'd7,  6'd4,  6'd1
  };

  // Widths of the partial sums: one kernel row and the whole window.
  localparam int RowSumBits = 15;
  localparam int SumBits    = 17;

  // floor(x / 273) = (x * 245821) >> 26 holds for every x below 2^17.
  localparam int RecipBits  = 18;
  localparam int RecipShift = 26;
  localparam logic [RecipBits-1:0] Recip = RecipBits'(245821);
  localparam int ProdBits   = SumBits + RecipBits;

  typedef logic [23:0] pixel_t;

  // One color channel of a packed pixel: 0 red, 1 green, 2 blue.
  function automatic logic [7:0] channel(input pixel_t px, input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = px[23:16];
      2'd1:    v = px[15:8];
      default: v = px[7:0];
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gb5_if.sv
// ----------------------------------------------------------------------------
// gb5 channel interfaces
// Valid/ready channels for pixels in, blurred pixels out and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface gb5_pix_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, cmd, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, cmd, in_red, in_green, in_blue, output ready);
endinterface

interface gb5_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blurred_red;
  logic [7:0] blurred_green;
  logic [7:0] blurred_blue;
  logic       frame_end;
  modport source (output valid, blurred_red, blurred_green, blurred_blue, frame_end,
                  input ready);
  modport sink   (input valid, blurred_red, blurred_green, blurred_blue, frame_end,
                  output ready);
endinterface

interface gb5_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gb5_pkg::CfgIdxBits-1:0]  index;
  logic [gb5_pkg::CfgDataBits-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/gaussian_blur_5x5_unit.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_unit: streaming 5x5 Gaussian blur of RGB pixels
// Line memories, a 5x5 tap window and a short arithmetic pipeline.
// ----------------------------------------------------------------------------
// The unit takes one pixel transfer per clock in raster order and returns
// each pixel blurred by the 1-4-7-4-1 / 4-16-26-16-4 / 7-26-41-26-7 kernel,
// divided by 273 with truncation; taps outside the frame count as zero. A
// result belongs to the input two rows and two pixels earlier, so after the
// last pixel the source sends 2*width+2 drain transfers (cmd = 1) to push out
// the rest; the last result carries frame_end. Throughput is one transfer per
// clock while res_out.ready does not hold back the output; a result passes
// five registers: the line memory read, the window register, the row sums,
// the total and the reciprocal multiply. No clearing pass is needed after
// reset. Write the frame sizes only while the unit is idle.
`default_nettype none

module gaussian_blur_5x5_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  gb5_cfg_if.sink    cfg,
  gb5_pix_if.sink    pix_in,
  gb5_res_if.source  res_out
);

  localparam int ColBits  = gb5_pkg::ColBits;
  localparam int CW       = gb5_pkg::CntWBits;
  localparam int HBits    = gb5_pkg::HBits;
  localparam int RowBits  = gb5_pkg::RowBits;
  localparam int RsBits   = gb5_pkg::RowSumBits;
  localparam int SumBits  = gb5_pkg::SumBits;
  localparam int ProdBits = gb5_pkg::ProdBits;

  // Configuration registers.
  logic [gb5_pkg::CfgWBits-1:0] frame_width;
  logic [HBits-1:0]             frame_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= gb5_pkg::FrameWidthRst;
      frame_height <= gb5_pkg::FrameHeightRst;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        gb5_pkg::RegFrameWidth:  frame_width  <= cfg.data[gb5_pkg::CfgWBits-1:0];
        gb5_pkg::RegFrameHeight: frame_height <= cfg.data[HBits-1:0];
        default: ;
      endcase
    end
  end

  // Sizes in use: width clamped to 1..MaxWidth, height at least 1.
  logic [CW-1:0]    w_used;
  logic [HBits-1:0] h_used;

  always_comb begin
    if (frame_width == '0) begin
      w_used = CW'(1);
    end else if (CW'(frame_width) > CW'(gb5_pkg::MaxWidth)) begin
      w_used = CW'(gb5_pkg::MaxWidth);
    end else begin
      w_used = CW'(frame_width);
    end
    h_used = (frame_height == '0) ? HBits'(1) : frame_height;
  end

  // Position counters.
  logic [ColBits-1:0] input_column;
  logic [RowBits-1:0] input_row;
  logic [ColBits-1:0] output_column;
  logic [HBits-1:0]   output_row;

  // Pipeline valid flags and the ready chain that lets each stage move.
  logic s1_valid, s2_valid, s3_valid, s4_valid, out_valid;
  logic out_free, s4_free, s3_free, s2_free, s1_free;

  assign out_free = !out_valid || res_out.ready;
  assign s4_free  = !s4_valid || out_free;
  assign s3_free  = !s3_valid || s4_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_free  = !s1_valid || s2_free;
  assign pix_in.ready = s1_free;

  // Decode of the incoming transfer against the current counters.
  logic               accept, wrap_frame, process;
  logic [ColBits-1:0] ic_e, oc_e;
  logic [RowBits-1:0] ir_e;
  logic [HBits-1:0]   or_e;
  gb5_pkg::pixel_t    pix;
  logic               emit, last;
  logic [4:0]         row_mask, col_mask;

  assign accept     = pix_in.valid && pix_in.ready;
  assign wrap_frame = (input_row >= RowBits'(h_used));
  assign process    = (pix_in.cmd == gb5_pkg::CmdPixel) || wrap_frame;

  always_comb begin
    logic [CW+1:0]  ic_x, w_x;
    logic [HBits:0] or_x, h_x;
    logic [CW:0]    oc_x, wc_x;
    // A pixel after the frame has run through starts a new frame.
    if (pix_in.cmd == gb5_pkg::CmdPixel && wrap_frame) begin
      ic_e = '0;
      ir_e = '0;
      oc_e = '0;
      or_e = '0;
    end else begin
      ic_e = input_column;
      ir_e = input_row;
      oc_e = output_column;
      or_e = output_row;
    end
    pix = (pix_in.cmd == gb5_pkg::CmdPixel) ?
          {pix_in.in_red, pix_in.in_green, pix_in.in_blue} : '0;

    // Emit once the linear position reaches 2*width+2.
    ic_x = (CW+2)'(ic_e);
    w_x  = (CW+2)'(w_used);
    if (ir_e == RowBits'(0)) begin
      emit = (ic_x >= (w_x << 1) + (CW+2)'(2));
    end else if (ir_e == RowBits'(1)) begin
      emit = (ic_x >= w_x + (CW+2)'(2));
    end else if (ir_e == RowBits'(2)) begin
      emit = (ic_x >= (CW+2)'(2));
    end else if (ir_e == RowBits'(3)) begin
      emit = !(w_x == (CW+2)'(1) && ic_x == '0);
    end else begin
      emit = 1'b1;
    end

    // Which window rows and columns lie inside the frame.
    or_x = (HBits+1)'(or_e);
    h_x  = (HBits+1)'(h_used);
    row_mask[0] = (or_x >= (HBits+1)'(2)) && (or_x < h_x + (HBits+1)'(2));
    row_mask[1] = (or_x >= (HBits+1)'(1)) && (or_x < h_x + (HBits+1)'(1));
    row_mask[2] = (or_x < h_x);
    row_mask[3] = (or_x + (HBits+1)'(1) < h_x);
    row_mask[4] = (or_x + (HBits+1)'(2) < h_x);
    oc_x = (CW+1)'(oc_e);
    wc_x = (CW+1)'(w_used);
    col_mask[0] = (oc_x >= (CW+1)'(2)) && (oc_x < wc_x + (CW+1)'(2));
    col_mask[1] = (oc_x >= (CW+1)'(1)) && (oc_x < wc_x + (CW+1)'(1));
    col_mask[2] = (oc_x < wc_x);
    col_mask[3] = (oc_x + (CW+1)'(1) < wc_x);
    col_mask[4] = (oc_x + (CW+1)'(2) < wc_x);
    last = (or_x + (HBits+1)'(1) >= h_x) && (oc_x + (CW+1)'(1) >= wc_x);
  end

  // Counter updates on each processed transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      input_column  <= '0;
      input_row     <= '0;
      output_column <= '0;
      output_row    <= '0;
    end else if (accept && process) begin
      if (emit && last) begin
        input_column  <= '0;
        input_row     <= '0;
        output_column <= '0;
        output_row    <= '0;
      end else begin
        if ((CW+1)'(ic_e) + (CW+1)'(1) >= (CW+1)'(w_used)) begin
          input_column <= '0;
          input_row    <= ir_e + RowBits'(1);
        end else begin
          input_column <= ic_e + ColBits'(1);
          input_row    <= ir_e;
        end
        if (emit) begin
          if ((CW+1)'(oc_e) + (CW+1)'(1) >= (CW+1)'(w_used)) begin
            output_column <= '0;
            output_row    <= or_e + HBits'(1);
          end else begin
            output_column <= oc_e + ColBits'(1);
            output_row    <= or_e;
          end
        end else begin
          output_column <= oc_e;
          output_row    <= or_e;
        end
      end
    end
  end

  // Four line memories, one per row modulo four; read before write.
  gb5_pkg::pixel_t line_rd [4];

  for (genvar b = 0; b < 4; b++) begin : g_line
    gb5_pkg::pixel_t line_mem [gb5_pkg::MaxWidth];

    always_ff @(posedge clk) begin
      if (accept && process) begin
        if (ir_e[1:0] == 2'(b)) begin
          line_mem[ic_e] <= pix;
        end
        line_rd[b] <= line_mem[ic_e];
      end
    end
  end

  // Stage 1: transfer held with its line memory reads.
  gb5_pkg::pixel_t s1_pix;
  logic [1:0]      s1_bank;
  logic            s1_emit, s1_last;
  logic [4:0]      s1_row_mask, s1_col_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= process;
    end else if (s2_free) begin
      s1_valid <= 1'b0;
    end
    if (accept && process) begin
      s1_pix      <= pix;
      s1_bank     <= ir_e[1:0];
      s1_emit     <= emit;
      s1_last     <= last;
      s1_row_mask <= row_mask;
      s1_col_mask <= col_mask;
    end
  end

  // Stage 2: the tap window shifts left and takes the new column.
  gb5_pkg::pixel_t tap_window [25];
  logic            s2_last;
  logic [4:0]      s2_row_mask, s2_col_mask;
  logic            s1_move;

  assign s1_move = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      for (int i = 0; i < 25; i++) begin
        tap_window[i] <= '0;
      end
    end else begin
      if (s1_move) begin
        s2_valid <= s1_emit;
        for (int k = 0; k < 5; k++) begin
          for (int m = 0; m < 4; m++) begin
            tap_window[k*5+m] <= tap_window[k*5+m+1];
          end
        end
        for (int k = 0; k < 4; k++) begin
          tap_window[k*5+4] <= line_rd[2'(s1_bank + 2'(k))];
        end
        tap_window[24] <= s1_pix;
      end else if (s3_free) begin
        s2_valid <= 1'b0;
      end
    end
    if (s1_move) begin
      s2_last     <= s1_last;
      s2_row_mask <= s1_row_mask;
      s2_col_mask <= s1_col_mask;
    end
  end

  // Stage 3: weighted sum of each kernel row, per channel.
  logic [RsBits-1:0] row_sum [5][3];
  logic [RsBits-1:0] s3_sum  [5][3];
  logic              s3_last;

  always_comb begin
    logic [RsBits-1:0] acc;
    for (int k = 0; k < 5; k++) begin
      for (int c = 0; c < 3; c++) begin
        acc = '0;
        for (int m = 0; m < 5; m++) begin
          if (s2_col_mask[m]) begin
            acc = acc + RsBits'(gb5_pkg::channel(tap_window[k*5+m], 2'(c)))
                      * RsBits'(gb5_pkg::Kernel[k*5+m]);
          end
        end
        row_sum[k][c] = s2_row_mask[k] ? acc : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_free) begin
      s3_valid <= s2_valid;
    end
    if (s3_free && s2_valid) begin
      s3_sum  <= row_sum;
      s3_last <= s2_last;
    end
  end

  // Stage 4: total over the five rows.
  logic [SumBits-1:0] s4_total [3];
  logic               s4_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_free) begin
      s4_valid <= s3_valid;
    end
    if (s4_free && s3_valid) begin
      for (int c = 0; c < 3; c++) begin
        s4_total[c] <= SumBits'(s3_sum[0][c]) + SumBits'(s3_sum[1][c])
                     + SumBits'(s3_sum[2][c]) + SumBits'(s3_sum[3][c])
                     + SumBits'(s3_sum[4][c]);
      end
      s4_last <= s3_last;
    end
  end

  // Output register: division by 273 through the reciprocal multiply.
  logic [ProdBits-1:0] quot [3];
  logic [7:0]          out_chan [3];
  logic                out_last;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quot[c] = ProdBits'(s4_total[c]) * ProdBits'(gb5_pkg::Recip);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s4_valid;
    end
    if (out_free && s4_valid) begin
      for (int c = 0; c < 3; c++) begin
        out_chan[c] <= quot[c][gb5_pkg::RecipShift +: 8];
      end
      out_last <= s4_last;
    end
  end

  assign res_out.valid         = out_valid;
  assign res_out.blurred_red   = out_chan[0];
  assign res_out.blurred_green = out_chan[1];
  assign res_out.blurred_blue  = out_chan[2];
  assign res_out.frame_end     = out_last;

endmodule

`default_nettype wire
